// ----- hw/rtl/lrgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lrgs_pkg
// Shared types, constants and the per-column Life rule for the row stepper.
// ----------------------------------------------------------------------------
package lrgs_pkg;

    localparam int ROW_W      = 64;   // width of a row on the stream
    localparam int COLS       = 64;   // live columns, 3..64
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int NBR_W      = 4;    // neighbor count 0..8

    localparam logic [ROW_W-1:0] COL_MASK = {ROW_W{1'b1}} >> (ROW_W - COLS);

    localparam logic [NBR_W-1:0] BIRTH_CNT   = NBR_W'(3);
    localparam logic [NBR_W-1:0] SURVIVE_CNT = NBR_W'(2);

    // One queued row: the window around it plus frame position.
    typedef struct packed {
        logic [ROW_W-1:0] upper;
        logic [ROW_W-1:0] middle;
        logic [ROW_W-1:0] row;
        logic             have_prev;  // a row above 'row' is still owed
        logic             last;
    } lrgs_job_t;

    // Next generation of 'here', all columns in parallel. Rows are masked.
    function automatic logic [ROW_W-1:0] next_gen(
        input logic [ROW_W-1:0] above,
        input logic [ROW_W-1:0] here,
        input logic [ROW_W-1:0] below
    );
        logic [ROW_W+1:0] a;
        logic [ROW_W+1:0] h;
        logic [ROW_W+1:0] b;
        logic [NBR_W-1:0] n;
        logic [ROW_W-1:0] res;
        a   = {1'b0, above, 1'b0};
        h   = {1'b0, here,  1'b0};
        b   = {1'b0, below, 1'b0};
        res = '0;
        for (int c = 0; c < ROW_W; c++) begin
            n = NBR_W'(a[c]) + NBR_W'(a[c+1]) + NBR_W'(a[c+2])
              + NBR_W'(h[c]) + NBR_W'(h[c+2])
              + NBR_W'(b[c]) + NBR_W'(b[c+1]) + NBR_W'(b[c+2]);
            res[c] = (n == BIRTH_CNT) || (h[c+1] && (n == SURVIVE_CNT));
        end
        return res & COL_MASK;
    endfunction

endpackage

// ----- hw/rtl/lrgs_front.sv -----
// ----------------------------------------------------------------------------
// lrgs_front
// Takes rows, keeps the two rows above, queues one window per row.
// ----------------------------------------------------------------------------
module lrgs_front import lrgs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ROW_W-1:0] s_tdata,   // [63:0] row_cells
    input  logic             s_tlast,   // last_row
    input  logic             q_full,
    output logic             q_push,
    output lrgs_job_t        q_data
);

    logic [ROW_W-1:0] upper_reg,  upper_next;
    logic [ROW_W-1:0] middle_reg, middle_next;
    logic [1:0]       seen_reg,   seen_next;
    logic [ROW_W-1:0] row;
    logic             have_prev;

    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && s_tready;
    assign row       = s_tdata & COL_MASK;
    assign have_prev = (seen_reg != 2'd0);

    always_comb begin
        q_data.upper     = upper_reg;
        q_data.middle    = middle_reg;
        q_data.row       = row;
        q_data.have_prev = have_prev;
        q_data.last      = s_tlast;
    end

    always_comb begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        seen_next   = seen_reg;
        if (q_push) begin
            if (s_tlast) begin
                // frame closes, back to the empty window
                upper_next  = '0;
                middle_next = '0;
                seen_next   = 2'd0;
            end else begin
                upper_next  = have_prev ? middle_reg : '0;
                middle_next = row;
                seen_next   = (seen_reg == 2'd2) ? seen_reg : seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg  <= '0;
            middle_reg <= '0;
            seen_reg   <= 2'd0;
        end else begin
            upper_reg  <= upper_next;
            middle_reg <= middle_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

// ----- hw/rtl/lrgs_fifo.sv -----
// ----------------------------------------------------------------------------
// lrgs_fifo
// Short queue of row windows between front and back.
// ----------------------------------------------------------------------------
module lrgs_fifo import lrgs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  lrgs_job_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output lrgs_job_t head_data
);

    lrgs_job_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg,  count_next;
    logic               do_pop;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/lrgs_back.sv -----
// ----------------------------------------------------------------------------
// lrgs_back
// Expands each queued window into zero, one or two result rows.
// ----------------------------------------------------------------------------
module lrgs_back import lrgs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  lrgs_job_t        head_data,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [ROW_W-1:0] m_tdata,   // [63:0] next_row_cells
    output logic             m_tlast    // frame_done
);

    logic             phase_reg, phase_next;   // 1: row above already sent
    logic             valid_reg, valid_next;
    logic [ROW_W-1:0] data_reg,  data_next;
    logic             last_reg,  last_next;

    logic             job_upper;   // result for the row above
    logic             job_valid;
    logic             out_free;
    logic             advance;
    logic [ROW_W-1:0] w_above, w_here, w_below;

    assign job_upper = head_data.have_prev && !phase_reg;
    assign job_valid = job_upper || head_data.last;
    assign out_free  = !valid_reg || m_tready;
    // windows that produce nothing drain without waiting on the output
    assign advance   = head_valid && (out_free || !job_valid);
    assign pop       = advance && !(job_upper && head_data.last);

    always_comb begin
        if (job_upper) begin
            w_above = head_data.upper;
            w_here  = head_data.middle;
            w_below = head_data.row;
        end else begin
            w_above = head_data.have_prev ? head_data.middle : '0;
            w_here  = head_data.row;
            w_below = '0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (advance) begin
            phase_next = job_upper && head_data.last;
        end
        if (out_free) begin
            valid_next = head_valid && job_valid;
            data_next  = next_gen(w_above, w_here, w_below);
            last_next  = !job_upper;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- hw/rtl/life_row_generation_step.sv -----
// ----------------------------------------------------------------------------
// life_row_generation_step
// One generation of Life (B3/S23) over a grid streamed in row by row.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one grid row per beat, top to bottom; tlast marks the bottom
//   row. Bits at and above COLS are ignored, cells off the grid are dead.
//   m_ channel: next-generation rows. Each row after the first releases the
//   row above it; the bottom row also releases its own, with tlast set.
//   A one-row frame gives a single beat with tlast.
// Path: a released result goes through the queue, then the output register.
// Throughput: one row per cycle inside a frame while the queue has room. The
//   bottom row of a frame of N >= 2 rows yields two results and holds the
//   back end until both are out; the four-entry queue hides this for isolated
//   frames, a run of short frames fills it and drops s_tready.
// Reset: window and queue empty, no frame in progress, m_tvalid low.
// Stall: with m_tready low the output register holds; rows are still taken
//   until the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module life_row_generation_step import lrgs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ROW_W-1:0] s_tdata,   // [63:0] row_cells
    input  logic             s_tlast,   // last_row
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [ROW_W-1:0] m_tdata,   // [63:0] next_row_cells
    output logic             m_tlast    // frame_done
);

    logic      q_push;
    logic      q_full;
    lrgs_job_t q_in;
    logic      q_pop;
    logic      q_head_valid;
    lrgs_job_t q_head;

    lrgs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    lrgs_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head)
    );

    lrgs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_data  (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- tb/sv/tb_life_row_generation_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_row_generation_step
// Self-checking bench for the row-streamed Life (B3/S23) generation stepper.
// Rows go in on the s_ stream as directed frames (one- and two-row frames,
// a blinker, a glider, edge columns, a solid block) and then random frames of
// random length and density. Every accepted row updates a bit-level model of
// the row window, which queues the next-generation rows it owes. Each m_ beat
// is checked against the oldest queued row. Both sides stall in random bursts.
// ----------------------------------------------------------------------------

class life_scoreboard;

    typedef struct {
        logic [lrgs_pkg::ROW_W-1:0] cells;
        logic                       done;
    } next_row_t;

    next_row_t                  owed_rows[$];
    logic [lrgs_pkg::ROW_W-1:0] upper_row;
    logic [lrgs_pkg::ROW_W-1:0] middle_row;
    int unsigned                rows_seen;
    int unsigned                errors;
    int unsigned                beats_checked;

    function new();
        upper_row     = '0;
        middle_row    = '0;
        rows_seen     = 0;
        errors        = 0;
        beats_checked = 0;
    endfunction

    // Neighbor count per column; cells off the grid are dead.
    function logic [lrgs_pkg::ROW_W-1:0] evolve_row(
        input logic [lrgs_pkg::ROW_W-1:0] above,
        input logic [lrgs_pkg::ROW_W-1:0] here,
        input logic [lrgs_pkg::ROW_W-1:0] below
    );
        logic [lrgs_pkg::ROW_W-1:0] nxt;
        int                         n;
        int                         k;
        nxt = '0;
        for (int c = 0; c < lrgs_pkg::COLS; c++) begin
            n = 0;
            for (int dc = -1; dc <= 1; dc++) begin
                k = c + dc;
                if (k >= 0 && k < lrgs_pkg::COLS) begin
                    n += int'(above[k]) + int'(below[k]);
                    if (dc != 0)
                        n += int'(here[k]);
                end
            end
            nxt[c] = (n == 3) || (here[c] && n == 2);
        end
        return nxt;
    endfunction

    function void take_row(input logic [lrgs_pkg::ROW_W-1:0] cells, input logic last);
        logic [lrgs_pkg::ROW_W-1:0] row;
        row = cells & lrgs_pkg::COL_MASK;
        if (rows_seen != 0)
            owed_rows.push_back('{cells: evolve_row(upper_row, middle_row, row), done: 1'b0});
        if (last) begin
            owed_rows.push_back('{cells: evolve_row((rows_seen != 0) ? middle_row : '0, row, '0),
                                  done: 1'b1});
            upper_row  = '0;
            middle_row = '0;
            rows_seen  = 0;
        end else begin
            upper_row  = (rows_seen != 0) ? middle_row : '0;
            middle_row = row;
            if (rows_seen < 2)
                rows_seen++;
        end
    endfunction

    function int unsigned pending();
        return owed_rows.size();
    endfunction

    task report(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_row(input logic [lrgs_pkg::ROW_W-1:0] cells, input logic done);
        next_row_t exp_row;
        beats_checked++;
        if (owed_rows.size() == 0) begin
            report($sformatf("unexpected beat tdata=%h tlast=%b", cells, done));
        end else begin
            exp_row = owed_rows.pop_front();
            if (cells !== exp_row.cells)
                report($sformatf("beat %0d next_row_cells got %h want %h",
                                 beats_checked, cells, exp_row.cells));
            if (done !== exp_row.done)
                report($sformatf("beat %0d frame_done got %b want %b",
                                 beats_checked, done, exp_row.done));
        end
    endtask

endclass

module tb_life_row_generation_step;
    import lrgs_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int STALL_LIMIT = 600;
    localparam int RANDOM_ROWS = 650;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [ROW_W-1:0] s_tdata;   // [63:0] row_cells
    logic             s_tlast;   // last_row
    logic             m_tvalid;
    logic             m_tready;
    logic [ROW_W-1:0] m_tdata;   // [63:0] next_row_cells
    logic             m_tlast;   // frame_done

    life_scoreboard   life_sb = new();
    logic             calm;
    int unsigned      idle_cycles;

    life_row_generation_step DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Result side: ready with random stall bursts, none once calm.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            life_sb.check_row(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [ROW_W-1:0] rand_row(input int density);
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        logic [ROW_W-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (density)
            0: return a & b & c;
            1: return a & b;
            2: return a | b;
            3: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return a;
        endcase
    endfunction

    task automatic send_row(input logic [ROW_W-1:0] cells, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= cells;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        life_sb.take_row(cells, last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every owed row has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (life_sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int          sent;
        int          len;
        int          density;
        logic        paused;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        calm        = 1'b0;
        idle_cycles = 0;
        sent        = 0;
        paused      = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // one-row frames
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        send_row(64'h7, 1'b1);
        // vertical blinker
        send_row(64'h2, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h2, 1'b1);
        // both edge columns
        send_row(64'hC000_0000_0000_0003, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'hC000_0000_0000_0003, 1'b1);
        // glider against the high edge
        send_row(64'h2 << 61, 1'b0);
        send_row(64'h4 << 61, 1'b0);
        send_row(64'h7 << 61, 1'b0);
        send_row('0, 1'b0);
        send_row('0, 1'b1);
        // two-row frames
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);
        // solid block of four rows
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);

        drain_results();

        while (sent < RANDOM_ROWS) begin
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(1, 10);
            density = $urandom_range(0, 5);
            if (sent >= RANDOM_ROWS - 90)
                calm = 1'b1;
            if (!paused && sent >= RANDOM_ROWS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            for (int r = 0; r < len; r++) begin
                send_row(rand_row(density), r == len - 1);
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (life_sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (life_sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
